// File: design/gif_lzw_encoder_assert.svh
// Assertion macros shared by the encoder's checkers.
`ifndef GIF_LZW_ENCODER_ASSERT_SVH
`define GIF_LZW_ENCODER_ASSERT_SVH

// Antecedent at one edge implies the consequent at the next edge.
`define GLZW_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("glzw: next-cycle check failed");

// Same, but suspended while reset is asserted.
`define GLZW_NEXT_ON(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("glzw: next-cycle check failed out of reset");

`endif

// File: design/glzw_pkg.sv
package glzw_pkg;

    // Widest code and width field carried between the sequencer and the packer.
    localparam int CODE_FIELD_W  = 16;
    localparam int WIDTH_FIELD_W = 5;

    // Dictionary entries carry a stream tag; tag zero never matches a live stream.
    localparam int EPOCH_BITS = 4;

    // Hash multipliers; only the low table-index bits are used.
    localparam logic [31:0] HASH_K1 = 32'h9E3779B1;
    localparam logic [31:0] HASH_K2 = 32'd40503;

    localparam logic [3:0] MIN_ROOT_BITS = 4'd2;
    localparam logic [3:0] RESET_CODE_SIZE = 4'd8;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic [CODE_FIELD_W-1:0]  code;
        logic [WIDTH_FIELD_W-1:0] width;
        logic                     flush;
    } code_req_t;

endpackage

// File: design/glzw_ram.sv
module glzw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/glzw_packer.sv
module glzw_packer import glzw_pkg::*; #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      req_valid,
    output logic      req_ready,
    input  code_req_t req,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int ACC_W = MAX_CODE_BITS + 8;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     flush_reg, flush_next;
    logic                     m_valid_reg, m_valid_next;
    out_item_t                m_data_reg, m_data_next;
    logic                     out_free;
    logic                     have_byte;
    logic [MAX_CODE_BITS-1:0] code_mask;

    assign out_free  = !m_valid_reg || m_ready;
    assign have_byte = cnt_reg >= CNT_W'(8);
    assign req_ready = !have_byte && !flush_reg;
    assign code_mask = ~({MAX_CODE_BITS{1'b1}} << req.width);

    always_comb begin
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        flush_next   = flush_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (req_valid && req_ready) begin
            acc_next   = acc_reg | (ACC_W'(req.code[MAX_CODE_BITS-1:0] & code_mask) << cnt_reg);
            cnt_next   = cnt_reg + CNT_W'(req.width);
            flush_next = req.flush;
        end else if (out_free && have_byte) begin
            m_valid_next          = 1'b1;
            m_data_next.out_byte  = acc_reg[7:0];
            m_data_next.last_byte = flush_reg && (cnt_reg == CNT_W'(8));
            acc_next              = acc_reg >> 8;
            cnt_next              = cnt_reg - CNT_W'(8);
            if (cnt_reg == CNT_W'(8)) begin
                flush_next = 1'b0;
            end
        end else if (out_free && flush_reg) begin
            // drain the partial final byte; upper bits are already zero
            m_valid_next          = 1'b1;
            m_data_next.out_byte  = acc_reg[7:0];
            m_data_next.last_byte = 1'b1;
            acc_next              = '0;
            cnt_next              = '0;
            flush_next            = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            cnt_reg     <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            cnt_reg     <= cnt_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/gif_lzw_encoder.sv
// Channel   | Handshake          | Payload    | Use
// ----------+--------------------+------------+-------------------------------------
// input     | s_valid / s_ready  | s_data     | one symbol and its end-of-stream mark
// output    | m_valid / m_ready  | m_data     | one packed byte and its final mark
// config    | cfg_we             | cfg_wdata  | initial code size, used at stream start
//
// The first symbol of a stream also passes through setup and the clear code, and the last
// symbol adds the final code and the end code; a dictionary miss adds a packer request,
// and every extra hash probe repeats the dictionary check.
// After reset the dictionary memory is swept with s_ready low; the sweep runs again at
// the start of the sixteenth stream and every fifteenth after that.
// A stalled m_ready holds the packer, which holds the sequencer when it has a code ready.
module gif_lzw_encoder import glzw_pkg::*; #(
    parameter int MAX_CODE_BITS = 12,
    parameter int TABLE_DEPTH   = 8192,
    parameter int SYMBOL_BITS   = 8
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_we,
    input  logic [3:0] cfg_wdata
);

    localparam int CODE_W  = MAX_CODE_BITS;
    localparam int NF_W    = MAX_CODE_BITS + 1;
    localparam int CW_W    = WIDTH_FIELD_W;
    localparam int TB      = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = EPOCH_BITS + CODE_W + SYMBOL_BITS + CODE_W;

    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST = '1;
    localparam logic [TB-1:0]         K1 = TB'(HASH_K1);
    localparam logic [TB-1:0]         K2 = TB'(HASH_K2);

    typedef enum logic [9:0] {
        ST_SWEEP = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_BEGIN = 10'b0000000100,
        ST_CLEAR = 10'b0000001000,
        ST_SYM   = 10'b0000010000,
        ST_CHECK = 10'b0000100000,
        ST_MISS  = 10'b0001000000,
        ST_TAIL  = 10'b0010000000,
        ST_FINAL = 10'b0100000000,
        ST_END   = 10'b1000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    in_stream_reg, in_stream_next;
    logic                    active_reg, active_next;
    logic                    resume_reg, resume_next;
    logic [EPOCH_BITS-1:0]   epoch_reg, epoch_next;
    logic [3:0]              cfg_size_reg, cfg_size_next;
    logic [3:0]              root_reg, root_next;
    logic [CW_W-1:0]         cw_reg, cw_next;
    logic [NF_W-1:0]         free_reg, free_next;
    logic [CODE_W-1:0]       prefix_reg, prefix_next;
    logic [7:0]              sym_raw_reg, sym_raw_next;
    logic                    last_reg, last_next;
    logic [TB-1:0]           probe_addr_reg, probe_addr_next;
    logic [TB-1:0]           probe_cnt_reg, probe_cnt_next;
    logic [TB-1:0]           sweep_addr_reg, sweep_addr_next;
    logic                    slot_ok_reg, slot_ok_next;

    logic                    ram_we;
    logic [TB-1:0]           ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;
    logic [EPOCH_BITS-1:0]   rd_epoch;
    logic [CODE_W-1:0]       rd_prefix, rd_code;
    logic [SYMBOL_BITS-1:0]  rd_sym;

    logic                    pk_valid, pk_ready;
    code_req_t               pk_req;

    logic [7:0]              root_mask;
    logic [SYMBOL_BITS-1:0]  sym_m;
    logic [CODE_W-1:0]       clear_code;
    logic [3:0]              root_clamped;
    logic [TB-1:0]           hash_a, hash_b;

    assign root_mask  = 8'((9'h1 << root_reg) - 9'h1);
    assign sym_m      = SYMBOL_BITS'(sym_raw_reg & root_mask);
    assign clear_code = CODE_W'(1) << root_reg;
    assign hash_a     = TB'(prefix_reg) * K1;
    assign hash_b     = TB'(sym_m) * K2;

    // Clamp the root size into [2, SYMBOL_BITS].
    always_comb begin
        priority if (cfg_size_reg < MIN_ROOT_BITS) begin
            root_clamped = MIN_ROOT_BITS;
        end else if (cfg_size_reg > 4'(SYMBOL_BITS)) begin
            root_clamped = 4'(SYMBOL_BITS);
        end else begin
            root_clamped = cfg_size_reg;
        end
    end

    assign {rd_epoch, rd_prefix, rd_sym, rd_code} = ram_rdata;

    always_comb begin
        state_next      = state_reg;
        in_stream_next  = in_stream_reg;
        active_next     = active_reg;
        resume_next     = resume_reg;
        epoch_next      = epoch_reg;
        cfg_size_next   = cfg_we ? cfg_wdata : cfg_size_reg;
        root_next       = root_reg;
        cw_next         = cw_reg;
        free_next       = free_reg;
        prefix_next     = prefix_reg;
        sym_raw_next    = sym_raw_reg;
        last_next       = last_reg;
        probe_addr_next = probe_addr_reg;
        probe_cnt_next  = probe_cnt_reg;
        sweep_addr_next = sweep_addr_reg;
        slot_ok_next    = slot_ok_reg;
        ram_we          = 1'b0;
        ram_waddr       = probe_addr_reg;
        ram_wdata       = {epoch_reg, prefix_reg, sym_m, CODE_W'(free_reg)};
        pk_valid        = 1'b0;
        pk_req.code     = CODE_FIELD_W'(prefix_reg);
        pk_req.width    = cw_reg;
        pk_req.flush    = 1'b0;
        s_ready         = 1'b0;

        unique case (state_reg)
            ST_SWEEP: begin
                // write tag zero everywhere; no live stream uses it
                ram_we          = 1'b1;
                ram_waddr       = sweep_addr_reg;
                ram_wdata       = '0;
                sweep_addr_next = sweep_addr_reg + TB'(1);
                if (sweep_addr_reg == '1) begin
                    epoch_next  = '0;
                    resume_next = 1'b0;
                    state_next  = resume_reg ? ST_BEGIN : ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sym_raw_next = s_data.symbol;
                    last_next    = s_data.last_symbol;
                    state_next   = in_stream_reg ? ST_SYM : ST_BEGIN;
                end
            end
            ST_BEGIN: begin
                if (epoch_reg == EPOCH_LAST) begin
                    sweep_addr_next = '0;
                    resume_next     = 1'b1;
                    state_next      = ST_SWEEP;
                end else begin
                    epoch_next     = epoch_reg + EPOCH_BITS'(1);
                    root_next      = root_clamped;
                    cw_next        = CW_W'(root_clamped) + CW_W'(1);
                    free_next      = (NF_W'(1) << root_clamped) + NF_W'(2);
                    active_next    = 1'b0;
                    in_stream_next = 1'b1;
                    state_next     = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                pk_valid    = 1'b1;
                pk_req.code = CODE_FIELD_W'(clear_code);
                if (pk_ready) begin
                    state_next = ST_SYM;
                end
            end
            ST_SYM: begin
                if (!active_reg) begin
                    prefix_next = CODE_W'(sym_m);
                    active_next = 1'b1;
                    state_next  = ST_TAIL;
                end else begin
                    probe_addr_next = hash_a ^ hash_b;
                    probe_cnt_next  = '0;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (rd_epoch != epoch_reg) begin
                    slot_ok_next = 1'b1;
                    state_next   = ST_MISS;
                end else if (rd_prefix == prefix_reg && rd_sym == sym_m) begin
                    prefix_next = rd_code;
                    state_next  = ST_TAIL;
                end else if (probe_cnt_reg == '1) begin
                    slot_ok_next = 1'b0;
                    state_next   = ST_MISS;
                end else begin
                    probe_addr_next = probe_addr_reg + TB'(1);
                    probe_cnt_next  = probe_cnt_reg + TB'(1);
                end
            end
            ST_MISS: begin
                pk_valid = 1'b1;
                if (pk_ready) begin
                    if (!free_reg[MAX_CODE_BITS] && slot_ok_reg) begin
                        ram_we    = 1'b1;
                        free_next = free_reg + NF_W'(1);
                        if (free_reg == (NF_W'(1) << cw_reg)
                                && cw_reg < CW_W'(MAX_CODE_BITS)) begin
                            cw_next = cw_reg + CW_W'(1);
                        end
                    end
                    prefix_next = CODE_W'(sym_m);
                    state_next  = ST_TAIL;
                end
            end
            ST_TAIL: begin
                state_next = last_reg ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL: begin
                pk_valid = 1'b1;
                if (pk_ready) begin
                    state_next = ST_END;
                end
            end
            ST_END: begin
                pk_valid     = 1'b1;
                pk_req.code  = CODE_FIELD_W'(clear_code + CODE_W'(1));
                pk_req.flush = 1'b1;
                if (pk_ready) begin
                    in_stream_next = 1'b0;
                    active_next    = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            in_stream_reg  <= 1'b0;
            active_reg     <= 1'b0;
            resume_reg     <= 1'b0;
            epoch_reg      <= '0;
            cfg_size_reg   <= RESET_CODE_SIZE;
            sweep_addr_reg <= '0;
        end else begin
            state_reg      <= state_next;
            in_stream_reg  <= in_stream_next;
            active_reg     <= active_next;
            resume_reg     <= resume_next;
            epoch_reg      <= epoch_next;
            cfg_size_reg   <= cfg_size_next;
            sweep_addr_reg <= sweep_addr_next;
        end
        root_reg       <= root_next;
        cw_reg         <= cw_next;
        free_reg       <= free_next;
        prefix_reg     <= prefix_next;
        sym_raw_reg    <= sym_raw_next;
        last_reg       <= last_next;
        probe_addr_reg <= probe_addr_next;
        probe_cnt_reg  <= probe_cnt_next;
        slot_ok_reg    <= slot_ok_next;
    end

    // Dictionary: read always follows the next probe address.
    glzw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_dict (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (probe_addr_next),
        .rdata (ram_rdata)
    );

    glzw_packer #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (pk_valid),
        .req_ready (pk_ready),
        .req       (pk_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: design/glzw_checker.sv
module glzw_checker import glzw_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

`include "gif_lzw_encoder_assert.svh"

    // Hold a stalled output byte.
    `GLZW_NEXT_ON(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    // Sweep the dictionary after reset before taking symbols.
    `GLZW_NEXT(a_sweep_after_reset, !aresetn, !s_ready)
    // Drop output valid out of reset.
    `GLZW_NEXT(a_out_idle_after_reset, !aresetn, !m_valid)
    // One symbol at a time: a transfer closes the input until it is worked off.
    `GLZW_NEXT_ON(a_one_at_a_time, s_valid && s_ready, !s_ready)

endmodule

bind gif_lzw_encoder glzw_checker u_glzw_checker (.*);

// File: dv/tb_top.sv
module tb_top;
    import glzw_pkg::*;

    // Widest code the dictionary may hand out, as in the block's default build.
    localparam int CODE_LIMIT_BITS = 12;
    // Idle cycles allowed with no transfer on either channel. The dictionary sweep
    // after reset and on tag wraparound holds s_ready low.
    localparam int STALL_LIMIT = 60000;
    // Cycles to let the block settle before a register write and at the end.
    localparam int SETTLE_CYCLES = 40;
    // Table entry value meaning "leave the register alone".
    localparam int NO_WRITE = 16;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    logic      cfg_we;
    logic [3:0] cfg_wdata;

    gif_lzw_encoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Encoder model: own copy of the register, dictionary and bit packer.
    // The hash table never runs out of slots (at most 4096 entries in 8192),
    // so an associative array keyed by {prefix, symbol} behaves the same.
    // ------------------------------------------------------------------
    logic [3:0] size_reg;
    int         root_w;
    int         code_w;
    int         free_code;
    int         prefix;
    bit         have_prefix;
    bit         streaming;
    logic [31:0] pack_acc;
    int         pack_cnt;
    int         dict [int];

    out_item_t  byte_q[$];      // packed bytes still owed by the block
    out_item_t  step_bytes[$];  // bytes caused by the current symbol

    int  n_fail;
    int  n_syms;
    int  n_bytes;
    int  n_streams;
    bit  dict_filled;

    function automatic void model_reset();
        size_reg  = RESET_CODE_SIZE;
        streaming = 1'b0;
        have_prefix = 1'b0;
        pack_acc  = '0;
        pack_cnt  = 0;
    endfunction

    function automatic void pack_code(int code, int w);
        pack_acc |= (code & ((1 << w) - 1)) << pack_cnt;
        pack_cnt += w;
        while (pack_cnt >= 8) begin
            step_bytes.push_back('{out_byte: pack_acc[7:0], last_byte: 1'b0});
            pack_acc = pack_acc >> 8;
            pack_cnt -= 8;
        end
    endfunction

    // Advance the model by one accepted symbol; leave the bytes in step_bytes.
    function automatic void encode_symbol(in_item_t it);
        int sym;
        int key;
        step_bytes.delete();
        if (!streaming) begin
            root_w = (size_reg < 2) ? 2 : (size_reg > 8) ? 8 : int'(size_reg);
            code_w = root_w + 1;
            free_code = (1 << root_w) + 2;
            dict.delete();
            have_prefix = 1'b0;
            pack_acc = '0;
            pack_cnt = 0;
            streaming = 1'b1;
            n_streams++;
            pack_code(1 << root_w, code_w);
        end
        sym = int'(it.symbol) & ((1 << root_w) - 1);
        key = (prefix << 8) | sym;
        if (!have_prefix) begin
            prefix = sym;
            have_prefix = 1'b1;
        end else if (dict.exists(key)) begin
            prefix = dict[key];
        end else begin
            pack_code(prefix, code_w);
            if (free_code < (1 << CODE_LIMIT_BITS)) begin
                dict[key] = free_code;
                if (free_code == (1 << code_w) && code_w < CODE_LIMIT_BITS)
                    code_w++;
                free_code++;
            end else begin
                dict_filled = 1'b1;
            end
            prefix = sym;
        end
        if (it.last_symbol) begin
            pack_code(prefix, code_w);
            pack_code((1 << root_w) + 1, code_w);
            if (pack_cnt > 0) begin
                step_bytes.push_back('{out_byte: pack_acc[7:0], last_byte: 1'b0});
                pack_acc = '0;
                pack_cnt = 0;
            end
            step_bytes[step_bytes.size()-1].last_byte = 1'b1;
            streaming = 1'b0;
            have_prefix = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the byte checker.
    // ------------------------------------------------------------------
    bit steady;     // suppress idling on both sides
    int stall_cnt;

    always @(negedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= steady ? 1'b1 : ($urandom_range(99) >= 27);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (byte_q.size() == 0) begin
                $error("unexpected byte transfer: out_byte=%0h last_byte=%0b",
                       m_data.out_byte, m_data.last_byte);
                n_fail++;
            end else begin
                out_item_t want;
                want = byte_q.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, m_data.out_byte);
                    n_fail++;
                end
                if (m_data.last_byte !== want.last_byte) begin
                    $error("last_byte: expected %0b, got %0b", want.last_byte,
                           m_data.last_byte);
                    n_fail++;
                end
            end
            n_bytes++;
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Offer one symbol, idling at random first; the model advances on transfer.
    // Valid is only lowered for an idle cycle, so it never drops and rises in one step.
    task automatic send_symbol(input logic [7:0] sym, input bit fin,
                               input bit use_typed, input out_item_t typed[$]);
        while (!steady && $urandom_range(99) < 27) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= '{symbol: sym, last_symbol: fin};
        do @(posedge aclk); while (!s_ready);
        encode_symbol('{symbol: sym, last_symbol: fin});
        n_syms++;
        // Where the bytes are typed in, they stand in for the model's.
        if (use_typed) begin
            if (typed.size() != step_bytes.size()) begin
                $error("byte count: expected %0d, got %0d from model",
                       typed.size(), step_bytes.size());
                n_fail++;
            end
            foreach (typed[i]) byte_q.push_back(typed[i]);
        end else begin
            foreach (step_bytes[i]) byte_q.push_back(step_bytes[i]);
        end
    endtask

    // Drain every owed byte, let the block settle, then write the register.
    task automatic write_size(input logic [3:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (byte_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        size_reg = val;
    endtask

    typedef struct {
        int         cfg;        // NO_WRITE leaves the register alone
        logic [7:0] sym;
        bit         fin;
        bit         typed;
    } step_row_t;

    // Directed part: default size after reset, size clamping at both ends,
    // masked symbols, repeated patterns for dictionary hits, one-symbol streams.
    step_row_t plan[] = '{
        '{NO_WRITE, 8'hFF, 1'b1, 1'b1},   // default size: clear, FF, end
        '{0,        8'hFF, 1'b0, 1'b0},   // below range -> 2 bits, symbol masked
        '{NO_WRITE, 8'h03, 1'b0, 1'b0},
        '{NO_WRITE, 8'h03, 1'b0, 1'b0},
        '{NO_WRITE, 8'h03, 1'b0, 1'b0},
        '{NO_WRITE, 8'h03, 1'b0, 1'b0},
        '{NO_WRITE, 8'h00, 1'b1, 1'b0},
        '{1,        8'h00, 1'b1, 1'b0},
        '{2,        8'h01, 1'b0, 1'b0},
        '{NO_WRITE, 8'h02, 1'b0, 1'b0},
        '{NO_WRITE, 8'h01, 1'b0, 1'b0},
        '{NO_WRITE, 8'h02, 1'b0, 1'b0},
        '{NO_WRITE, 8'h01, 1'b0, 1'b0},
        '{NO_WRITE, 8'h02, 1'b1, 1'b0},
        '{15,       8'h00, 1'b0, 1'b0},   // above range -> 8 bits
        '{NO_WRITE, 8'hFF, 1'b0, 1'b0},
        '{NO_WRITE, 8'h80, 1'b0, 1'b0},
        '{NO_WRITE, 8'h7F, 1'b1, 1'b0},
        '{8,        8'h55, 1'b0, 1'b0},
        '{NO_WRITE, 8'hAA, 1'b1, 1'b0},
        '{3,        8'hF7, 1'b0, 1'b0},
        '{NO_WRITE, 8'h08, 1'b0, 1'b0},
        '{NO_WRITE, 8'h07, 1'b1, 1'b0}
    };

    // Default size, one symbol FF: clear 256, code 255, end 257 at 9 bits.
    out_item_t first_bytes[$] = '{
        '{8'h00, 1'b0}, '{8'hFF, 1'b0}, '{8'h05, 1'b0}, '{8'h04, 1'b1}
    };

    initial begin
        out_item_t none[$];
        int        len;
        int        alpha;
        logic [7:0] pick;
        int        k;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        steady    = 1'b0;
        n_fail    = 0;
        n_syms    = 0;
        n_bytes   = 0;
        n_streams = 0;
        dict_filled = 1'b0;
        model_reset();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].cfg != NO_WRITE)
                write_size(plan[i].cfg[3:0]);
            send_symbol(plan[i].sym, plan[i].fin, plan[i].typed,
                        plan[i].typed ? first_bytes : none);
        end

        // Random streams: small alphabets make repeats and dictionary hits likely.
        while (n_syms < 240) begin
            if ($urandom_range(3) == 0)
                write_size(4'($urandom_range(15)));
            len   = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            alpha = $urandom_range(1, 3);
            steady = ($urandom_range(7) == 0);
            for (k = 0; k < len; k++) begin
                pick = 8'($urandom_range(255));
                // Keep upper bits random so masking is exercised, low bits narrow.
                if (alpha < 3)
                    pick = {pick[7:2], pick[1:0] & 2'(alpha)};
                send_symbol(pick, k == len - 1, 1'b0, none);
            end
            steady = 1'b0;
        end

        // One stream at 8 bits with no idling on either side.
        write_size(4'd8);
        steady = 1'b1;
        for (k = 0; k < 40; k++)
            send_symbol(8'($urandom_range(255)), k == 39, 1'b0, none);
        steady = 1'b0;

        // A few short streams at the smallest size.
        write_size(4'd2);
        for (k = 0; k < 20; k++)
            send_symbol(8'($urandom_range(255)), (k % 5) == 4, 1'b0, none);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (byte_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d symbols in %0d streams, %0d bytes checked, dictionary full: %0b",
                 n_syms, n_streams, n_bytes, dict_filled);
        if (n_fail == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
